[rtl/sha_pkg.sv]
// Shared types and constants of the SHA-256 byte stream hasher.
`default_nettype none

package sha_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } sha_vars_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PAD_MARK   = 8'h80;
  localparam logic [5:0]  LEN_START  = 6'd56;
  localparam logic [5:0]  LAST_BYTE  = 6'd63;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

endpackage

`default_nettype wire

[rtl/sha_if.sv]
// Valid/ready channel interfaces for the byte input and the digest output.
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

[rtl/sha_round.sv]
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
`default_nettype none

module sha_round import sha_pkg::*; (
  input  sha_vars_t   vars_i,
  input  logic [31:0] w0_i,
  input  logic [31:0] w1_i,
  input  logic [31:0] w9_i,
  input  logic [31:0] w14_i,
  input  logic [31:0] k_i,
  output sha_vars_t   vars_o,
  output logic [31:0] sched_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm_s0, sm_s1;

  always_comb begin
    big_s1 = rotr(vars_i.e, 6) ^ rotr(vars_i.e, 11) ^ rotr(vars_i.e, 25);
    ch     = (vars_i.e & vars_i.f) ^ (~vars_i.e & vars_i.g);
    t1     = vars_i.h + big_s1 + ch + k_i + w0_i;
    big_s0 = rotr(vars_i.a, 2) ^ rotr(vars_i.a, 13) ^ rotr(vars_i.a, 22);
    maj    = (vars_i.a & vars_i.b) ^ (vars_i.a & vars_i.c) ^ (vars_i.b & vars_i.c);
    t2     = big_s0 + maj;

    vars_o.h = vars_i.g;
    vars_o.g = vars_i.f;
    vars_o.f = vars_i.e;
    vars_o.e = vars_i.d + t1;
    vars_o.d = vars_i.c;
    vars_o.c = vars_i.b;
    vars_o.b = vars_i.a;
    vars_o.a = t1 + t2;

    // Word t+16 of the schedule, built from the sliding window w[t..t+15].
    sm_s0   = rotr(w1_i, 7) ^ rotr(w1_i, 18) ^ (w1_i >> 3);
    sm_s1   = rotr(w14_i, 17) ^ rotr(w14_i, 19) ^ (w14_i >> 10);
    sched_o = sm_s1 + w9_i + sm_s0 + w0_i;
  end

endmodule

`default_nettype wire

[rtl/sha256_byte_stream_hasher.sv]
// Top level: SHA-256 over a byte stream, one shared round unit under a sequencer.
// Absorb: one byte per cycle; byte 64 of a block starts a compression (load, 64 rounds, add).
// Finish: one padding byte per cycle to the end of the block, with a pause before the length,
// one or two compressions, then eight words, one per ready cycle.
// The round loop of the shared unit sets the rate; no item is taken during a compression.
// Reset (rst_n low, synchronous) loads the initial hash values and clears the counts.
`default_nettype none

module sha256_byte_stream_hasher import sha_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha_in_if.sink     in_chan,
  sha_out_if.source  out_chan
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PADZ   = 3'd1;
  localparam logic [2:0] S_PADLEN = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  sha_vars_t   vars_r, vars_nxt, vars_rnd;
  logic [31:0] sched;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        in_acc, out_acc;

  sha_round u_round (
    .vars_i  (vars_r),
    .w0_i    (win_r[0]),
    .w1_i    (win_r[1]),
    .w9_i    (win_r[9]),
    .w14_i   (win_r[14]),
    .k_i     (SHA_K[rnd_r]),
    .vars_o  (vars_rnd),
    .sched_o (sched)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign in_acc               = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = (state_r == S_OUT);
  assign out_acc              = out_chan.valid && out_chan.ready;
  assign out_chan.digest_word = hash_r[widx_r];
  assign out_chan.word_index  = widx_r;
  assign out_chan.last_word   = (widx_r == 3'd7);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    widx_nxt   = widx_r;
    bits_nxt   = bits_r;
    len_nxt    = len_r;
    hash_nxt   = hash_r;
    vars_nxt   = vars_r;
    shift_en   = 1'b0;
    shift_byte = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          shift_en = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
          if (in_chan.opcode == OP_ABSORB) begin
            shift_byte = in_chan.data_byte;
            if (cnt_r == LAST_BYTE) begin
              bits_nxt  = bits_r + BLOCK_BITS;
              ret_nxt   = S_IDLE;
              state_nxt = S_LOAD;
            end
          end else begin
            shift_byte = PAD_MARK;
            len_nxt    = bits_r + {55'd0, cnt_r, 3'd0};
            ret_nxt    = S_PADZ;
            state_nxt  = (cnt_r == LAST_BYTE) ? S_LOAD : S_PADZ;
          end
        end
      end
      S_PADZ: begin
        if (cnt_r == LEN_START) begin
          state_nxt = S_PADLEN;
        end else begin
          // Zero fill; a full block is compressed and filling resumes in the next one.
          shift_en = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
          if (cnt_r == LAST_BYTE) begin
            ret_nxt   = S_PADZ;
            state_nxt = S_LOAD;
          end
        end
      end
      S_PADLEN: begin
        shift_en   = 1'b1;
        shift_byte = len_r[63:56];
        len_nxt    = {len_r[55:0], 8'd0};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == LAST_BYTE) begin
          ret_nxt   = S_OUT;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        vars_nxt  = '{a: hash_r[0], b: hash_r[1], c: hash_r[2], d: hash_r[3],
                      e: hash_r[4], f: hash_r[5], g: hash_r[6], h: hash_r[7]};
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        vars_nxt = vars_rnd;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == LAST_BYTE) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        hash_nxt[0] = hash_r[0] + vars_r.a;
        hash_nxt[1] = hash_r[1] + vars_r.b;
        hash_nxt[2] = hash_r[2] + vars_r.c;
        hash_nxt[3] = hash_r[3] + vars_r.d;
        hash_nxt[4] = hash_r[4] + vars_r.e;
        hash_nxt[5] = hash_r[5] + vars_r.f;
        hash_nxt[6] = hash_r[6] + vars_r.g;
        hash_nxt[7] = hash_r[7] + vars_r.h;
        widx_nxt    = 3'd0;
        state_nxt   = ret_r;
      end
      S_OUT: begin
        if (out_acc) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            hash_nxt  = SHA_IV;
            cnt_nxt   = 6'd0;
            bits_nxt  = 64'd0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The window doubles as the byte buffer: bytes shift in at the low byte of word 15, and
  // during rounds it slides by one schedule word.
  always_comb begin
    win_nxt = win_r;
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], shift_byte};
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = sched;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= 6'd0;
      rnd_r   <= 6'd0;
      widx_r  <= 3'd0;
      bits_r  <= 64'd0;
      hash_r  <= SHA_IV;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      bits_r  <= bits_nxt;
      hash_r  <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    vars_r <= vars_nxt;
    win_r  <= win_nxt;
  end

endmodule

`default_nettype wire

[rtl/sha_checker.sv]
// Port-level assertions for the SHA-256 hasher and their bind to the top level.
`default_nettype none

module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // A stalled digest word holds its value and index.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // No new transaction is taken while digest words are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during digest output");

  // Digest words follow one another in index order.
  a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // After the eighth word the block is back to taking input.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("block did not return to idle after the last word");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .digest_word (out_chan.digest_word),
  .word_index  (out_chan.word_index),
  .last_word   (out_chan.last_word)
);

`default_nettype wire
